// File: hw/rtl/mfs_pkg.sv
// shared types and constants of the manchester frame synchronizer
`default_nettype none

package mfs_pkg;

    // width of the sync word configuration registers
    localparam int SYNC_CFG_W = 9;

    // register indexes on the configuration port
    localparam logic [2:0] REG_NORMAL_SYNC    = 3'd0;
    localparam logic [2:0] REG_TEST_SYNC      = 3'd1;
    localparam logic [2:0] REG_LOCK_ONES      = 3'd2;
    localparam logic [2:0] REG_EARLY_ONES     = 3'd3;
    localparam logic [2:0] REG_SEARCH_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_FRAME_LENGTH   = 3'd5;

    // register reset values
    localparam logic [SYNC_CFG_W-1:0] RST_NORMAL_SYNC    = 9'd47;
    localparam logic [SYNC_CFG_W-1:0] RST_TEST_SYNC      = 9'd208;
    localparam logic [4:0]            RST_LOCK_ONES      = 5'd12;
    localparam logic [4:0]            RST_EARLY_ONES     = 5'd10;
    localparam logic [5:0]            RST_SEARCH_TIMEOUT = 6'd30;
    localparam logic [7:0]            RST_FRAME_LENGTH   = 8'd120;

    typedef enum logic [1:0] {
        MODE_ONES = 2'd0,
        MODE_SYNC = 2'd1,
        MODE_RECV = 2'd2
    } t_mode;

    typedef struct packed {
        logic [SYNC_CFG_W-1:0] normal_sync;
        logic [SYNC_CFG_W-1:0] test_sync;
        logic [4:0]            lock_ones;
        logic [4:0]            early_ones;
        logic [5:0]            search_timeout;
        logic [7:0]            frame_length;
    } t_cfg;

    typedef struct packed {
        logic       emit;
        logic       frame_bit;
        logic [7:0] bit_index;
        logic       self_test;
        logic       frame_end;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/mfs_framer.sv
// manchester bit decoder and sync word framer state machine
`default_nettype none

module mfs_framer #(
    parameter int SYNC_WIDTH     = 9,
    parameter int MAX_FRAME_BITS = 144
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic           i_half,
    input  wire mfs_pkg::t_cfg  i_cfg,
    output mfs_pkg::t_result    o_res
);

    localparam int POS_W = $clog2(MAX_FRAME_BITS + 1);
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;
    localparam int SW_W  = (SYNC_WIDTH > mfs_pkg::SYNC_CFG_W) ? SYNC_WIDTH
                                                               : mfs_pkg::SYNC_CFG_W;
    localparam logic [CMP_W-1:0] MAX_POS = CMP_W'(MAX_FRAME_BITS);

    logic                  r_second_half, n_second_half;
    mfs_pkg::t_mode        r_mode, n_mode;
    logic [4:0]            r_run, n_run;
    logic [5:0]            r_seen, n_seen;
    logic [SYNC_WIDTH-1:0] r_shift, n_shift;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_test, n_test;

    logic                  w_bit;
    logic [SW_W-1:0]       w_normal_ext, w_test_ext;
    logic [SYNC_WIDTH-1:0] w_normal, w_test;
    logic                  w_in_sync;
    logic [SYNC_WIDTH-1:0] w_sw_shift;
    logic [6:0]            w_sw_next;
    logic [5:0]            w_sw_seen;
    logic                  w_hit_normal, w_hit_test, w_timeout;
    logic [4:0]            w_run_inc;
    logic [CMP_W-1:0]      w_pos_ext, w_pos_inc, w_len_ext, w_limit;
    logic                  w_last;
    logic                  w_do_sync;

    // equal halves decode to the inverse of the second half, and so do
    // both proper transitions: the bit is always the inverted second half
    assign w_bit = ~i_half;

    assign w_normal_ext = SW_W'(i_cfg.normal_sync);
    assign w_test_ext   = SW_W'(i_cfg.test_sync);
    assign w_normal     = w_normal_ext[SYNC_WIDTH-1:0];
    assign w_test       = w_test_ext[SYNC_WIDTH-1:0];

    // sync word step, also used for the zero that ends an early run
    assign w_in_sync    = (r_mode == mfs_pkg::MODE_SYNC);
    assign w_sw_shift   = w_in_sync ? {r_shift[SYNC_WIDTH-2:0], w_bit} : '0;
    assign w_sw_next    = w_in_sync ? ({1'b0, r_seen} + 7'd1) : 7'd1;
    assign w_sw_seen    = w_sw_next[6] ? 6'd63 : w_sw_next[5:0];
    assign w_hit_normal = (w_sw_shift == w_normal);
    assign w_hit_test   = (w_sw_shift == w_test);
    assign w_timeout    = (w_sw_next > {1'b0, i_cfg.search_timeout});

    assign w_run_inc = (r_run != 5'd31) ? (r_run + 5'd1) : r_run;

    assign w_pos_ext = CMP_W'(r_pos);
    assign w_pos_inc = (w_pos_ext < MAX_POS) ? (w_pos_ext + CMP_W'(1)) : w_pos_ext;
    assign w_len_ext = CMP_W'(i_cfg.frame_length);
    assign w_limit   = (w_len_ext > MAX_POS) ? MAX_POS : w_len_ext;
    assign w_last    = (w_pos_inc >= w_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_half <= 1'b0;
            r_mode        <= mfs_pkg::MODE_ONES;
            r_run         <= '0;
            r_seen        <= '0;
            r_shift       <= '0;
            r_pos         <= '0;
            r_test        <= 1'b0;
        end else begin
            r_second_half <= n_second_half;
            r_mode        <= n_mode;
            r_run         <= n_run;
            r_seen        <= n_seen;
            r_shift       <= n_shift;
            r_pos         <= n_pos;
            r_test        <= n_test;
        end
    end

    always_comb begin
        n_second_half = r_second_half;
        n_mode        = r_mode;
        n_run         = r_run;
        n_seen        = r_seen;
        n_shift       = r_shift;
        n_pos         = r_pos;
        n_test        = r_test;
        w_do_sync     = 1'b0;
        o_res         = '0;

        if (i_step) begin
            n_second_half = ~r_second_half;
            if (r_second_half) begin
                case (r_mode)
                    mfs_pkg::MODE_ONES: begin
                        if (w_bit) begin
                            n_run = w_run_inc;
                            if (w_run_inc >= i_cfg.lock_ones) begin
                                n_mode  = mfs_pkg::MODE_SYNC;
                                n_seen  = {1'b0, w_run_inc};
                                n_shift = '0;
                            end
                        end else begin
                            n_run = '0;
                            if (r_run >= i_cfg.early_ones) begin
                                w_do_sync = 1'b1;
                            end
                        end
                    end
                    mfs_pkg::MODE_SYNC: begin
                        w_do_sync = 1'b1;
                    end
                    default: begin
                        // receiving
                        o_res.emit      = 1'b1;
                        o_res.frame_bit = w_bit;
                        o_res.bit_index = w_pos_ext[7:0];
                        o_res.self_test = r_test;
                        o_res.frame_end = w_last;
                        if (w_last) begin
                            n_mode = mfs_pkg::MODE_ONES;
                            n_run  = '0;
                            n_pos  = '0;
                        end else begin
                            n_pos = w_pos_inc[POS_W-1:0];
                        end
                    end
                endcase

                if (w_do_sync) begin
                    n_mode  = mfs_pkg::MODE_SYNC;
                    n_shift = w_sw_shift;
                    n_seen  = w_sw_seen;
                    if (w_hit_normal) begin
                        n_mode = mfs_pkg::MODE_RECV;
                        n_pos  = '0;
                        n_test = 1'b0;
                    end else if (w_hit_test) begin
                        n_mode = mfs_pkg::MODE_RECV;
                        n_pos  = '0;
                        n_test = 1'b1;
                    end else if (w_timeout) begin
                        n_mode = mfs_pkg::MODE_ONES;
                        n_run  = '0;
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_pos) <= MAX_POS)
        else $error("frame position beyond maximum frame length");

    a_sync_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == mfs_pkg::MODE_SYNC) |-> (r_seen != 6'd0))
        else $error("sync word search without any counted bit");

    a_end_to_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.emit && o_res.frame_end) |=> (r_mode == mfs_pkg::MODE_ONES))
        else $error("framer did not return to ones search after last bit");

    a_ones_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == mfs_pkg::MODE_ONES) |-> (r_pos == '0))
        else $error("frame position not cleared outside a frame");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/manchester_frame_sync.sv
// top level of the manchester decoder with sync word framer
// path: a half-symbol transfer is registered in the input register, then decoded and
//   framed into the result register
// throughput: one half-symbol per cycle, at most one result per two half-symbols,
//   and a result held on the output stalls the input
// reset: synchronous active low, clears half-symbol phase, framer and valid flags, sets config defaults
`default_nettype none

module manchester_frame_sync #(
    parameter int SYNC_WIDTH     = 9,
    parameter int MAX_FRAME_BITS = 144
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // half-symbol input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_half_symbol_high,
    // frame bit output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_frame_bit,
    output logic [7:0]       o_bit_index,
    output logic             o_self_test,
    output logic             o_frame_end
);

    mfs_pkg::t_cfg    r_cfg;
    mfs_pkg::t_result w_res;

    logic       r_in_valid;
    logic       r_in_half;
    logic       w_advance;
    logic       w_cfg_wr;
    logic [2:0] w_reg_idx;

    logic       r_out_valid;
    logic       r_out_bit;
    logic [7:0] r_out_index;
    logic       r_out_test;
    logic       r_out_end;

    // ---------------------------------------------------------------
    // configuration registers, no wait states
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_sync    <= mfs_pkg::RST_NORMAL_SYNC;
            r_cfg.test_sync      <= mfs_pkg::RST_TEST_SYNC;
            r_cfg.lock_ones      <= mfs_pkg::RST_LOCK_ONES;
            r_cfg.early_ones     <= mfs_pkg::RST_EARLY_ONES;
            r_cfg.search_timeout <= mfs_pkg::RST_SEARCH_TIMEOUT;
            r_cfg.frame_length   <= mfs_pkg::RST_FRAME_LENGTH;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                mfs_pkg::REG_NORMAL_SYNC:    r_cfg.normal_sync    <= pwdata[8:0];
                mfs_pkg::REG_TEST_SYNC:      r_cfg.test_sync      <= pwdata[8:0];
                mfs_pkg::REG_LOCK_ONES:      r_cfg.lock_ones      <= pwdata[4:0];
                mfs_pkg::REG_EARLY_ONES:     r_cfg.early_ones     <= pwdata[4:0];
                mfs_pkg::REG_SEARCH_TIMEOUT: r_cfg.search_timeout <= pwdata[5:0];
                mfs_pkg::REG_FRAME_LENGTH:   r_cfg.frame_length   <= pwdata[7:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            mfs_pkg::REG_NORMAL_SYNC:    prdata = 32'(r_cfg.normal_sync);
            mfs_pkg::REG_TEST_SYNC:      prdata = 32'(r_cfg.test_sync);
            mfs_pkg::REG_LOCK_ONES:      prdata = 32'(r_cfg.lock_ones);
            mfs_pkg::REG_EARLY_ONES:     prdata = 32'(r_cfg.early_ones);
            mfs_pkg::REG_SEARCH_TIMEOUT: prdata = 32'(r_cfg.search_timeout);
            mfs_pkg::REG_FRAME_LENGTH:   prdata = 32'(r_cfg.frame_length);
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // input register: holds one half-symbol until the framer takes it
    // ---------------------------------------------------------------
    // the framer steps on a held half-symbol when the result register is free or being drained
    assign w_advance  = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_half <= i_half_symbol_high;
        end
    end

    // ---------------------------------------------------------------
    // decoder and framer, one half-symbol per step
    // ---------------------------------------------------------------
    mfs_framer #(
        .SYNC_WIDTH     (SYNC_WIDTH),
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_half  (r_in_half),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // ---------------------------------------------------------------
    // result register: loaded on a step that yields a frame bit
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.emit) begin
            r_out_bit   <= w_res.frame_bit;
            r_out_index <= w_res.bit_index;
            r_out_test  <= w_res.self_test;
            r_out_end   <= w_res.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_frame_bit = r_out_bit;
    assign o_bit_index = r_out_index;
    assign o_self_test = r_out_test;
    assign o_frame_end = r_out_end;

`ifndef SYNTHESIS
    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> (!r_out_valid || i_out_ready))
        else $error("framer stepped while a result was still waiting");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res.emit) |=> o_out_valid)
        else $error("frame bit lost on its way to the result register");

    a_input_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_in_ready) |-> (r_out_valid && !i_out_ready))
        else $error("input held without an output stall");
`endif

endmodule

`default_nettype wire
